/* hw/rtl/rbcc_pkg.sv */
// Shared types and constants of the ring buffer claim/commit engine.
package rbcc_pkg;

	localparam int CAP_W  = 11;
	localparam int HEAD_W = 12;
	localparam int SUM_W  = 13;
	localparam int OFF_W  = 10;
	localparam int OP_W   = 3;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [CAP_W-1:0]  CAP_RESET     = 11'd1024;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY = 2'd0;

	typedef logic [OP_W-1:0] opcode_t;

	localparam opcode_t OP_PUT_CLAIM  = 3'd0;
	localparam opcode_t OP_PUT_FINISH = 3'd1;
	localparam opcode_t OP_GET_CLAIM  = 3'd2;
	localparam opcode_t OP_GET_FINISH = 3'd3;
	localparam opcode_t OP_PUT        = 3'd4;
	localparam opcode_t OP_GET        = 3'd5;

	// Source of the next result beat loaded into the output register
	typedef enum logic [2:0] {
		OSRC_NONE,
		OSRC_CLAIM,
		OSRC_FINISH,
		OSRC_FIRST,
		OSRC_SECOND
	} out_src_t;

	typedef struct packed {
		logic     load;
		logic     claim;
		logic     claim2;
		logic     finish;
		logic     commit;
		out_src_t osrc;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    seg2_nz;
		logic    out_free;
	} dp_sts_t;

endpackage

/* hw/rtl/rbcc_req_if.sv */
// Request channel: opcode and length beats into the engine.
interface rbcc_req_if import rbcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [CAP_W-1:0] length;

	modport source (output valid, output opcode, output length, input ready);
	modport sink (input valid, input opcode, input length, output ready);
endinterface

/* hw/rtl/rbcc_rsp_if.sv */
// Result channel: segment offset, grant, status and last-beat marker.
interface rbcc_rsp_if import rbcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] offset;
	logic [CAP_W-1:0] granted;
	logic             status;
	logic             last;

	modport source (output valid, output offset, output granted, output status,
		output last, input ready);
	modport sink (input valid, input offset, input granted, input status,
		input last, output ready);
endinterface

/* hw/rtl/rbcc_ctrl.sv */
// Controller that sequences claim, second claim, commit and result beats.
module rbcc_ctrl import rbcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SECOND,
		ST_COMMIT,
		ST_EMIT2
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	assign in_ready = ready_q;

	// Decode state into datapath commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ready_q && in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.opcode) inside
					OP_PUT_CLAIM, OP_GET_CLAIM: begin
						if (sts.out_free) begin
							cmd.claim = 1'b1;
							cmd.osrc  = OSRC_CLAIM;
							state_d   = ST_IDLE;
						end
					end
					OP_PUT_FINISH, OP_GET_FINISH: begin
						if (sts.out_free) begin
							cmd.finish = 1'b1;
							cmd.osrc   = OSRC_FINISH;
							state_d    = ST_IDLE;
						end
					end
					OP_PUT, OP_GET: begin
						cmd.claim = 1'b1;
						state_d   = ST_SECOND;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SECOND: begin
				cmd.claim2 = 1'b1;
				state_d    = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					cmd.osrc   = OSRC_FIRST;
					state_d    = sts.seg2_nz ? ST_EMIT2 : ST_IDLE;
				end
			end
			ST_EMIT2: begin
				if (sts.out_free) begin
					cmd.osrc = OSRC_SECOND;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

endmodule

/* hw/rtl/rbcc_datapath.sv */
// Pointer datapath: span positions, claim and commit arithmetic, result register.
module rbcc_datapath import rbcc_pkg::*; #(
	parameter int RING_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr,
	input  logic [CAP_W-1:0] cfg_data,
	output logic [CAP_W-1:0] capacity,
	input  opcode_t          opcode_in,
	input  logic [CAP_W-1:0] length_in,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OFF_W-1:0] out_offset,
	output logic [CAP_W-1:0] out_granted,
	output logic             out_status,
	output logic             out_last
);

	localparam logic [CAP_W-1:0] CAP_RST_EFF =
		(RING_DEPTH < 1024) ? CAP_W'(RING_DEPTH) : CAP_RESET;

	logic [CAP_W-1:0]  capacity_q;
	logic [CAP_W-1:0]  cap_q;
	opcode_t           op_q;
	logic [CAP_W-1:0]  len_q;
	logic [CAP_W-1:0]  put_tail_q;
	logic [CAP_W-1:0]  get_tail_q;
	logic [HEAD_W-1:0] put_head_q;
	logic [HEAD_W-1:0] get_head_q;
	logic [CAP_W-1:0]  committed_q;
	logic [CAP_W-1:0]  g1_q;
	logic [OFF_W-1:0]  off1_q;
	logic [CAP_W-1:0]  g2_q;
	logic [OFF_W-1:0]  off2_q;
	logic              out_valid_q;
	logic [OFF_W-1:0]  offset_q;
	logic [CAP_W-1:0]  granted_q;
	logic              status_q;
	logic              last_q;

	logic              is_put;
	logic [CAP_W-1:0]  cap_eff;
	logic [CAP_W-1:0]  tail_sel;
	logic [HEAD_W-1:0] head_sel;
	logic [HEAD_W-1:0] put_claim;
	logic [HEAD_W-1:0] get_claim;
	logic [HEAD_W-1:0] span_claim;
	logic [SUM_W-1:0]  occ;
	logic [CAP_W-1:0]  free_amt;
	logic [CAP_W-1:0]  used_amt;
	logic [CAP_W-1:0]  avail;
	logic [HEAD_W-1:0] head_wrap;
	logic [CAP_W-1:0]  h;
	logic [CAP_W-1:0]  lim;
	logic [CAP_W-1:0]  req;
	logic [CAP_W-1:0]  g_lim;
	logic [CAP_W-1:0]  g;
	logic              need2;
	logic [HEAD_W-1:0] head_next;
	logic [CAP_W-1:0]  fin_n;
	logic              fin_ok;
	logic [HEAD_W-1:0] tail_sum;
	logic [CAP_W-1:0]  tail_next;
	logic              commit_en;
	logic [CAP_W-1:0]  committed_next;

	assign capacity = capacity_q;

	// Clamp the written capacity to 1..RING_DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			cap_eff = CAP_W'(1);
		end else if (32'(cfg_data) > RING_DEPTH) begin
			cap_eff = CAP_W'(RING_DEPTH);
		end else begin
			cap_eff = cfg_data;
		end
	end

	// Select the span of the current opcode
	assign is_put = (op_q == OP_PUT_CLAIM) || (op_q == OP_PUT_FINISH) || (op_q == OP_PUT);
	assign tail_sel = is_put ? put_tail_q : get_tail_q;
	assign head_sel = is_put ? put_head_q : get_head_q;

	// Outstanding claims of both spans
	assign put_claim = (put_head_q >= HEAD_W'(put_tail_q)) ?
		put_head_q - HEAD_W'(put_tail_q) : '0;
	assign get_claim = (get_head_q >= HEAD_W'(get_tail_q)) ?
		get_head_q - HEAD_W'(get_tail_q) : '0;
	assign span_claim = is_put ? put_claim : get_claim;

	// Free and used space, saturated at zero
	assign occ = SUM_W'(committed_q) + SUM_W'(put_claim);
	assign free_amt = (occ < SUM_W'(cap_q)) ? CAP_W'(SUM_W'(cap_q) - occ) : '0;
	assign used_amt = (HEAD_W'(committed_q) > get_claim) ?
		CAP_W'(HEAD_W'(committed_q) - get_claim) : '0;
	assign avail = is_put ? free_amt : used_amt;

	// Claim: grant min of request, room to ring end and available space
	assign head_wrap = (head_sel >= HEAD_W'(cap_q)) ? head_sel - HEAD_W'(cap_q) : head_sel;
	assign h         = CAP_W'(head_wrap);
	assign lim       = cap_q - h;
	assign req       = cmd.claim2 ? len_q - g1_q : len_q;
	assign g_lim     = (req > lim) ? lim : req;
	assign g         = (g_lim > avail) ? avail : g_lim;
	assign need2     = (g1_q != '0) && (len_q > g1_q);
	assign head_next = head_sel + HEAD_W'(g);

	// Finish: commit from the tail and wrap it
	assign fin_n     = cmd.commit ? g1_q + g2_q : len_q;
	assign fin_ok    = HEAD_W'(fin_n) <= span_claim;
	assign tail_sum  = HEAD_W'(tail_sel) + HEAD_W'(fin_n);
	assign tail_next = (tail_sum >= HEAD_W'(cap_q)) ?
		CAP_W'(tail_sum - HEAD_W'(cap_q)) : CAP_W'(tail_sum);
	assign commit_en = cmd.commit || (cmd.finish && fin_ok);
	assign committed_next = is_put ? committed_q + fin_n : committed_q - fin_n;

	// Status back to the controller
	assign sts.opcode   = op_q;
	assign sts.seg2_nz  = (g2_q != '0);
	assign sts.out_free = !out_valid_q || out_ready;

	// Configuration, span positions and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			cap_q       <= CAP_RST_EFF;
			put_tail_q  <= '0;
			get_tail_q  <= '0;
			put_head_q  <= '0;
			get_head_q  <= '0;
			committed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				capacity_q  <= cfg_data;
				cap_q       <= cap_eff;
				put_tail_q  <= '0;
				get_tail_q  <= '0;
				put_head_q  <= '0;
				get_head_q  <= '0;
				committed_q <= '0;
			end else if (cmd.claim || (cmd.claim2 && need2)) begin
				if (is_put) begin
					put_head_q <= head_next;
				end else begin
					get_head_q <= head_next;
				end
			end else if (commit_en) begin
				committed_q <= committed_next;
				if (is_put) begin
					put_tail_q <= tail_next;
					put_head_q <= HEAD_W'(tail_next);
				end else begin
					get_tail_q <= tail_next;
					get_head_q <= HEAD_W'(tail_next);
				end
			end
			if (cmd.osrc != OSRC_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the item and the segments, load the result beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode_in;
			len_q <= length_in;
		end
		if (cmd.claim) begin
			g1_q   <= g;
			off1_q <= h[OFF_W-1:0];
		end
		if (cmd.claim2) begin
			g2_q   <= need2 ? g : '0;
			off2_q <= h[OFF_W-1:0];
		end
		case (cmd.osrc)
			OSRC_CLAIM: begin
				offset_q  <= h[OFF_W-1:0];
				granted_q <= g;
				status_q  <= 1'b0;
				last_q    <= 1'b1;
			end
			OSRC_FINISH: begin
				offset_q  <= tail_sel[OFF_W-1:0];
				granted_q <= fin_ok ? len_q : '0;
				status_q  <= !fin_ok;
				last_q    <= 1'b1;
			end
			OSRC_FIRST: begin
				offset_q  <= off1_q;
				granted_q <= g1_q;
				status_q  <= 1'b0;
				last_q    <= (g2_q == '0);
			end
			OSRC_SECOND: begin
				offset_q  <= off2_q;
				granted_q <= g2_q;
				status_q  <= 1'b0;
				last_q    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_offset  = offset_q;
	assign out_granted = granted_q;
	assign out_status  = status_q;
	assign out_last    = last_q;

endmodule

/* hw/rtl/ring_buffer_claim_commit_engine_unit.sv */
// Top level of the ring buffer claim/commit engine with its APB register port.
//
// Index engine of a zero-copy byte ring: it keeps tail and head positions of a
// put span and a get span and answers claims (offset and granted bytes) and
// finishes (commit, wrap, error on overrun). One item is worked at a time by a
// single claim/commit unit sequenced by the controller: a claim or a finish is
// accepted, then executed with its result beat loaded; a combined put or get
// steps through accept, first claim, second claim, commit with the first beat
// and, for two result beats, the second beat. A stalled result channel holds
// the controller in a beat-loading state while the output register is full; the
// next item is accepted while a finished beat still waits. Writing the
// capacity register (address 0) empties the ring; write it only while idle.
module ring_buffer_claim_commit_engine_unit import rbcc_pkg::*; #(
	parameter int RING_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	rbcc_req_if.sink          req,
	rbcc_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic             cfg_wr;
	logic [CAP_W-1:0] capacity;

	// Decode the register write and read back
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
	assign prdata = (paddr == ADDR_CAPACITY) ? APB_DW'(capacity) : '0;

	rbcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbcc_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_data    (pwdata[CAP_W-1:0]),
		.capacity    (capacity),
		.opcode_in   (req.opcode),
		.length_in   (req.length),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_offset  (rsp.offset),
		.out_granted (rsp.granted),
		.out_status  (rsp.status),
		.out_last    (rsp.last)
	);

endmodule
